FILE: hw/rtl/ir2d_pkg.sv
// shared types, calibration table and per-segment constants for the ir adc to distance core
// no dependencies; used by every module of the block

package ir2d_pkg;

    localparam int CAL_ENTRIES = 15;
    localparam int SEG_COUNT   = CAL_ENTRIES - 1;
    localparam int SEG_W       = 4;
    localparam int ADC_W       = 12;
    localparam int MM_W        = 7;
    localparam int TDIFF_W     = 9;
    localparam int DEN_W       = 9;
    localparam int DV_W        = DEN_W + 1;
    localparam int DD_W        = 4;
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 16;
    localparam int X_W         = 12;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int Q_W         = 4;
    localparam int DIST_W      = 8;
    localparam int OFF_W       = 7;
    localparam int THR_W       = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_LEFT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_RIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WALL_THRESH  = 2'd2;

    // calibration points, sorted by falling adc value
    localparam logic [ADC_W-1:0] CAL_ADC [CAL_ENTRIES] = '{
        12'd1815, 12'd1554, 12'd1317, 12'd1158, 12'd1032,
        12'd957,  12'd880,  12'd801,  12'd735,  12'd700,
        12'd645,  12'd581,  12'd538,  12'd451,  12'd395
    };

    localparam logic [MM_W-1:0] CAL_MM [CAL_ENTRIES] = '{
        7'd20, 7'd25, 7'd30, 7'd35, 7'd40,
        7'd45, 7'd50, 7'd55, 7'd60, 7'd65,
        7'd70, 7'd75, 7'd80, 7'd90, 7'd100
    };

    // adc span of each segment
    localparam logic [DEN_W-1:0] SEG_DEN [SEG_COUNT] = '{
        9'd261, 9'd237, 9'd159, 9'd126, 9'd75, 9'd77, 9'd79,
        9'd66,  9'd35,  9'd55,  9'd64,  9'd43, 9'd87, 9'd56
    };

    // distance step of each segment
    localparam logic [DD_W-1:0] SEG_DD [SEG_COUNT] = '{
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd10, 4'd10
    };

    // floor(2^16 / (2*den)), the quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
        10'd125, 10'd138, 10'd206, 10'd260, 10'd436, 10'd425, 10'd414,
        10'd496, 10'd936, 10'd595, 10'd512, 10'd762, 10'd376, 10'd585
    };

    typedef struct packed {
        logic              side;
        logic              clamped;
        logic [SEG_W-1:0]  seg;
        logic [TDIFF_W-1:0] tdiff;
        logic [MM_W-1:0]   base_mm;
    } t_seg_item;

    typedef struct packed {
        logic [OFF_W-1:0] offset_left;
        logic [OFF_W-1:0] offset_right;
        logic [THR_W-1:0] wall_thresh;
    } t_cfg;

endpackage

FILE: hw/rtl/ir2d_front.sv
// front end: accepts a sample, finds its table segment or clamps it
// uses ir2d_pkg; feeds ir2d_fifo

module ir2d_front #(
    parameter int TABLE_POINTS = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_side,
    input  logic [ir2d_pkg::ADC_W-1:0]      i_raw_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ir2d_pkg::t_seg_item             o_item
);

    localparam int N_LIMITED = (TABLE_POINTS > ir2d_pkg::CAL_ENTRIES) ?
                               ir2d_pkg::CAL_ENTRIES : TABLE_POINTS;
    localparam int N_USED    = (N_LIMITED < 2) ? 2 : N_LIMITED;
    localparam int LAST      = N_USED - 1;

    logic [N_USED-1:0]            ge_vec;
    logic                         near_end;
    logic                         far_end;
    logic [ir2d_pkg::SEG_W-1:0]   seg;
    logic [ir2d_pkg::ADC_W-1:0]   diff;
    ir2d_pkg::t_seg_item          item;
    logic                         r_valid;
    ir2d_pkg::t_seg_item          r_item;

    always_comb begin
        for (int k = 0; k < N_USED; k++) begin
            ge_vec[k] = (i_raw_sample >= ir2d_pkg::CAL_ADC[k]);
        end
    end

    assign near_end = ge_vec[0];
    assign far_end  = (i_raw_sample <= ir2d_pkg::CAL_ADC[LAST]);

    // first segment whose lower point lies at or below the sample
    always_comb begin
        seg = '0;
        for (int k = LAST - 1; k >= 0; k--) begin
            if (ge_vec[k+1]) begin
                seg = ir2d_pkg::SEG_W'(k);
            end
        end
    end

    assign diff = ir2d_pkg::CAL_ADC[seg] - i_raw_sample;

    // a clamped item runs through the back end with zero offset into segment 0
    always_comb begin
        item.side = i_side;
        if (far_end) begin
            item.clamped = 1'b1;
            item.seg     = '0;
            item.tdiff   = '0;
            item.base_mm = ir2d_pkg::CAL_MM[LAST];
        end else if (near_end) begin
            item.clamped = 1'b1;
            item.seg     = '0;
            item.tdiff   = '0;
            item.base_mm = ir2d_pkg::CAL_MM[0];
        end else begin
            item.clamped = 1'b0;
            item.seg     = seg;
            item.tdiff   = diff[ir2d_pkg::TDIFF_W-1:0];
            item.base_mm = ir2d_pkg::CAL_MM[seg];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/ir2d_fifo.sv
// short queue of classified items between front and back end
// uses ir2d_pkg for the item type and depth

module ir2d_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  ir2d_pkg::t_seg_item  i_push_item,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output ir2d_pkg::t_seg_item  o_pop_item
);

    localparam int PTR_W = $clog2(ir2d_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    ir2d_pkg::t_seg_item  r_mem [ir2d_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_count != CNT_W'(ir2d_pkg::FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: hw/rtl/ir2d_back.sv
// back end: interpolation pipeline, offset subtraction and wall flag
// uses ir2d_pkg; pops items from ir2d_fifo

module ir2d_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  ir2d_pkg::t_seg_item                i_item,
    input  ir2d_pkg::t_cfg                     i_cfg,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ir2d_pkg::DIST_W-1:0] o_clear_mm,
    output logic                               o_wall_near,
    output logic                               o_range_clamped
);

    localparam int XW_FULL = ir2d_pkg::DV_W + ir2d_pkg::DD_W + 1;
    localparam int QD_W    = ir2d_pkg::Q_W + ir2d_pkg::DV_W;

    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: scaled numerator x = 2*t*dd + den and divisor 2*den
    logic                           r_v1;
    logic                           r_side1;
    logic                           r_cl1;
    logic [ir2d_pkg::MM_W-1:0]      r_base1;
    logic [ir2d_pkg::X_W-1:0]       r_x1;
    logic [ir2d_pkg::DV_W-1:0]      r_dv1;
    logic [ir2d_pkg::RECIP_W-1:0]   r_recip1;

    // stage 2: reciprocal product
    logic                           r_v2;
    logic                           r_side2;
    logic                           r_cl2;
    logic [ir2d_pkg::MM_W-1:0]      r_base2;
    logic [ir2d_pkg::X_W-1:0]       r_x2;
    logic [ir2d_pkg::DV_W-1:0]      r_dv2;
    logic [ir2d_pkg::PROD_W-1:0]    r_prod2;

    // stage 3: corrected quotient added to base distance
    logic                           r_v3;
    logic                           r_side3;
    logic                           r_cl3;
    logic [ir2d_pkg::MM_W-1:0]      r_mm3;

    // stage 4: output register
    logic                               r_v4;
    logic signed [ir2d_pkg::DIST_W-1:0] r_dist4;
    logic                               r_wall4;
    logic                               r_cl4;

    logic [ir2d_pkg::DEN_W-1:0]     den;
    logic [ir2d_pkg::DD_W-1:0]      dd;
    logic [XW_FULL-1:0]             x_full;
    logic [ir2d_pkg::Q_W-1:0]       q_est;
    logic [QD_W-1:0]                qd;
    logic [ir2d_pkg::X_W-1:0]       rem;
    logic [ir2d_pkg::Q_W-1:0]       q_fix;
    logic [ir2d_pkg::OFF_W-1:0]     offset;
    logic [ir2d_pkg::DIST_W-1:0]    net_mm;
    logic                           wall;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign den    = ir2d_pkg::SEG_DEN[i_item.seg];
    assign dd     = ir2d_pkg::SEG_DD[i_item.seg];
    assign x_full = XW_FULL'({i_item.tdiff, 1'b0}) * XW_FULL'(dd) + XW_FULL'(den);

    // estimate is never high and at most one low
    assign q_est = r_prod2[ir2d_pkg::RECIP_SHIFT +: ir2d_pkg::Q_W];
    assign qd    = QD_W'(q_est) * QD_W'(r_dv2);
    assign rem   = r_x2 - qd[ir2d_pkg::X_W-1:0];
    assign q_fix = q_est + ir2d_pkg::Q_W'(rem >= ir2d_pkg::X_W'(r_dv2));

    assign offset = r_side3 ? i_cfg.offset_right : i_cfg.offset_left;
    assign net_mm = {1'b0, r_mm3} - {1'b0, offset};
    assign wall   = $signed({net_mm[ir2d_pkg::DIST_W-1], net_mm}) <
                    $signed({1'b0, i_cfg.wall_thresh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_side1  <= i_item.side;
            r_cl1    <= i_item.clamped;
            r_base1  <= i_item.base_mm;
            r_x1     <= x_full[ir2d_pkg::X_W-1:0];
            r_dv1    <= {den, 1'b0};
            r_recip1 <= ir2d_pkg::SEG_RECIP[i_item.seg];
        end
        if (rdy2 && r_v1) begin
            r_side2 <= r_side1;
            r_cl2   <= r_cl1;
            r_base2 <= r_base1;
            r_x2    <= r_x1;
            r_dv2   <= r_dv1;
            r_prod2 <= ir2d_pkg::PROD_W'(r_x1) * ir2d_pkg::PROD_W'(r_recip1);
        end
        if (rdy3 && r_v2) begin
            r_side3 <= r_side2;
            r_cl3   <= r_cl2;
            r_mm3   <= r_base2 + ir2d_pkg::MM_W'(q_fix);
        end
        if (rdy4 && r_v3) begin
            r_dist4 <= $signed(net_mm);
            r_wall4 <= wall;
            r_cl4   <= r_cl3;
        end
    end

    assign o_valid         = r_v4;
    assign o_clear_mm      = r_dist4;
    assign o_wall_near     = r_wall4;
    assign o_range_clamped = r_cl4;

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> q_fix <= ir2d_pkg::Q_W'(10))
        else $error("interpolation quotient exceeds largest segment step");

    a_clamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_cl2 |-> r_x2 == ir2d_pkg::X_W'(r_dv2[ir2d_pkg::DV_W-1:1]))
        else $error("clamped item carries a nonzero segment offset");

    a_mm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_mm3 <= ir2d_pkg::CAL_MM[ir2d_pkg::CAL_ENTRIES-1])
        else $error("interpolated distance beyond table range");

endmodule

FILE: hw/rtl/ir_adc_to_distance_interp_core.sv
// top level of the infrared adc to distance converter with configuration registers
// uses ir2d_pkg, ir2d_front, ir2d_fifo and ir2d_back

// Converts one 12-bit infrared ADC sample per clock while the output does not stall into a
// signed distance in millimetres by piecewise linear interpolation over a fixed calibration
// table, rounded half up, then subtracts the selected side's mounting offset and flags a wall
// below the threshold. Samples at or past either table end clamp and set range_clamped. An
// accepted item passes through the front register that locates the table segment, then the
// four-entry queue and four back-end stages (scaled numerator, reciprocal multiply, quotient
// correction, offset and compare). The user must write the offset and threshold registers
// through the plain write port only while no item is in flight; the block itself does not
// enforce this.

module ir_adc_to_distance_interp_core #(
    parameter int TABLE_POINTS = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_side,
    input  logic [ir2d_pkg::ADC_W-1:0]            i_raw_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ir2d_pkg::DIST_W-1:0]    o_clear_mm,
    output logic                                  o_wall_near,
    output logic                                  o_range_clamped,
    input  logic                                  i_cfg_we,
    input  logic [ir2d_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [ir2d_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    ir2d_pkg::t_cfg       r_cfg;
    ir2d_pkg::t_seg_item  front_item;
    ir2d_pkg::t_seg_item  fifo_item;
    logic                 front_valid;
    logic                 front_ready;
    logic                 fifo_valid;
    logic                 back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ir2d_pkg::REG_OFFSET_LEFT: begin
                    r_cfg.offset_left <= i_cfg_wdata[ir2d_pkg::OFF_W-1:0];
                end
                ir2d_pkg::REG_OFFSET_RIGHT: begin
                    r_cfg.offset_right <= i_cfg_wdata[ir2d_pkg::OFF_W-1:0];
                end
                ir2d_pkg::REG_WALL_THRESH: begin
                    r_cfg.wall_thresh <= i_cfg_wdata[ir2d_pkg::THR_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    ir2d_front #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_side       (i_side),
        .i_raw_sample (i_raw_sample),
        .o_valid      (front_valid),
        .i_ready      (front_ready),
        .o_item       (front_item)
    );

    ir2d_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (fifo_valid),
        .i_pop_ready  (back_ready),
        .o_pop_item   (fifo_item)
    );

    ir2d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (fifo_valid),
        .o_ready         (back_ready),
        .i_item          (fifo_item),
        .i_cfg           (r_cfg),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_clear_mm      (o_clear_mm),
        .o_wall_near     (o_wall_near),
        .o_range_clamped (o_range_clamped)
    );

endmodule

FILE: tb/tb.sv
// testbench for ir_adc_to_distance_interp_core: directed and random adc samples, offset and
// threshold settings, random idling on both sides, results checked against an in-bench predictor
// depends on ir2d_pkg and the core rtl only

module tb;

    localparam int CAL_POINTS = 15;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 220;
    localparam int PIPE_SLACK = 12;

    localparam logic [ir2d_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // calibration points, falling adc value
    localparam int ADC_PTS [CAL_POINTS] = '{
        1815, 1554, 1317, 1158, 1032, 957, 880, 801, 735, 700, 645, 581, 538, 451, 395
    };
    localparam int MM_PTS [CAL_POINTS] = '{
        20, 25, 30, 35, 40, 45, 50, 55, 60, 65, 70, 75, 80, 90, 100
    };

    // table ends, neighbors of the ends, every interior point and two round-half-up samples
    localparam int CORNER_COUNT = 23;
    localparam logic [ir2d_pkg::ADC_W-1:0] CORNER_RAW [CORNER_COUNT] = '{
        12'd0, 12'd4095, 12'd395, 12'd394, 12'd396, 12'd1815, 12'd1816, 12'd1814,
        12'd1554, 12'd1317, 12'd1158, 12'd1032, 12'd957, 12'd880, 12'd801, 12'd735,
        12'd700, 12'd645, 12'd581, 12'd538, 12'd451, 12'd768, 12'd437
    };

    typedef struct {
        logic signed [ir2d_pkg::DIST_W-1:0] clear_mm;
        logic                               wall;
        logic                               clamped;
    } t_clear_result;

    class t_clear_scoreboard;
        t_clear_result pending_results [$];
        bit [ir2d_pkg::OFF_W-1:0] off_left;
        bit [ir2d_pkg::OFF_W-1:0] off_right;
        bit [ir2d_pkg::THR_W-1:0] wall_thr;
        int errors;

        function new();
            off_left  = '0;
            off_right = '0;
            wall_thr  = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [ir2d_pkg::CFG_ADDR_W-1:0] idx,
                              logic [ir2d_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                ir2d_pkg::REG_OFFSET_LEFT: off_left = val[ir2d_pkg::OFF_W-1:0];
                ir2d_pkg::REG_OFFSET_RIGHT: off_right = val[ir2d_pkg::OFF_W-1:0];
                ir2d_pkg::REG_WALL_THRESH: wall_thr = val[ir2d_pkg::THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int interpolate_mm(bit [ir2d_pkg::ADC_W-1:0] raw, output bit clamped);
            int i;
            int r0;
            int r1;
            int den;
            clamped = 1'b0;
            if (raw <= ADC_PTS[CAL_POINTS-1]) begin
                clamped = 1'b1;
                return MM_PTS[CAL_POINTS-1];
            end
            if (raw >= ADC_PTS[0]) begin
                clamped = 1'b1;
                return MM_PTS[0];
            end
            for (i = 0; i < CAL_POINTS - 1; i++) begin
                r0 = ADC_PTS[i];
                r1 = ADC_PTS[i+1];
                if (raw <= r0 && raw >= r1) begin
                    den = r0 - r1;
                    return MM_PTS[i] + (2 * (r0 - raw) * (MM_PTS[i+1] - MM_PTS[i]) + den)
                        / (2 * den);
                end
            end
            return MM_PTS[CAL_POINTS-1];
        endfunction

        function void note_sample(bit side, bit [ir2d_pkg::ADC_W-1:0] raw);
            t_clear_result e;
            bit clamped;
            int d;
            d = interpolate_mm(raw, clamped) - int'(side ? off_right : off_left);
            e.clear_mm = d[ir2d_pkg::DIST_W-1:0];
            e.wall     = (d < int'(wall_thr));
            e.clamped  = clamped;
            pending_results.push_back(e);
        endfunction

        function void mismatch(string field, logic signed [8:0] want, logic signed [8:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(logic signed [ir2d_pkg::DIST_W-1:0] clear_mm, logic wall,
                                   logic clamped);
            t_clear_result e;
            if (pending_results.size() == 0) begin
                mismatch("unexpected item clear_mm", 9'sd0, clear_mm);
                return;
            end
            e = pending_results.pop_front();
            if (clear_mm !== e.clear_mm) mismatch("clear_mm", e.clear_mm, clear_mm);
            if (wall !== e.wall) mismatch("wall_near", e.wall, wall);
            if (clamped !== e.clamped) mismatch("range_clamped", e.clamped, clamped);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic                                i_side = 1'b0;
    logic [ir2d_pkg::ADC_W-1:0]          i_raw_sample = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [ir2d_pkg::DIST_W-1:0]  o_clear_mm;
    logic                                o_wall_near;
    logic                                o_range_clamped;
    logic                                i_cfg_we = 1'b0;
    logic [ir2d_pkg::CFG_ADDR_W-1:0]     i_cfg_addr = '0;
    logic [ir2d_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;

    t_clear_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold_left = 0;

    ir_adc_to_distance_interp_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_side          (i_side),
        .i_raw_sample    (i_raw_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_clear_mm      (o_clear_mm),
        .o_wall_near     (o_wall_near),
        .o_range_clamped (o_range_clamped),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // every task below starts and ends right after a rising edge
    task automatic send_sample(input bit side, input bit [ir2d_pkg::ADC_W-1:0] raw);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid      <= 1'b1;
        i_side       <= side;
        i_raw_sample <= raw;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(side, raw);
    endtask

    task automatic cfg_write(input logic [ir2d_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [ir2d_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [ir2d_pkg::CFG_DATA_W-1:0] left,
                                  input logic [ir2d_pkg::CFG_DATA_W-1:0] right,
                                  input logic [ir2d_pkg::CFG_DATA_W-1:0] thr, input bit junk);
        cfg_write(ir2d_pkg::REG_OFFSET_LEFT, left);
        cfg_write(ir2d_pkg::REG_OFFSET_RIGHT, right);
        cfg_write(ir2d_pkg::REG_WALL_THRESH, thr);
        if (junk) cfg_write(REG_UNUSED, ir2d_pkg::CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    function automatic bit [ir2d_pkg::ADC_W-1:0] next_raw();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return ir2d_pkg::ADC_W'($urandom_range(1814, 396));
        // near a calibration point
        if (pick < 80) begin
            return ir2d_pkg::ADC_W'(ADC_PTS[$urandom_range(CAL_POINTS-1)] +
                                    $urandom_range(2) - 1);
        end
        return ir2d_pkg::ADC_W'($urandom);
    endfunction

    // receiver: checks results and stalls at random or for a requested hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_clear_mm, o_wall_near, o_range_clamped);
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #3000000;
        $display("FAIL ir_adc_to_distance_interp_core");
        $finish;
    end

    initial begin
        int k;
        int ph;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples at reset settings
        for (k = 0; k < CORNER_COUNT; k++) send_sample(k[0], CORNER_RAW[k]);
        i_valid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin
                    apply_settings(8'd127, 8'd127, 8'd255, 1'b0);
                    send_idle_pct = 65; recv_stall_pct = 0;
                end
                2: begin
                    apply_settings(8'd0, 8'd100, 8'd0, 1'b1);
                    send_idle_pct = 0;  recv_stall_pct = 65;
                end
                3: begin
                    apply_settings(8'd100, 8'd0, 8'd128, 1'b0);
                    send_idle_pct = 7;  recv_stall_pct = 7;
                end
                5: begin
                    // top bit of an offset write is dropped
                    apply_settings(8'hFF, 8'h80, 8'd60, 1'b0);
                    send_idle_pct = 65; recv_stall_pct = 0;
                end
                default: begin
                    apply_settings(ir2d_pkg::CFG_DATA_W'($urandom_range(127)),
                                   ir2d_pkg::CFG_DATA_W'($urandom_range(127)),
                                   ir2d_pkg::CFG_DATA_W'($urandom_range(255)), 1'b1);
                    send_idle_pct  = (ph == 6) ? 0 : (ph == 7) ? 7 : 0;
                    recv_stall_pct = (ph == 6) ? 65 : (ph == 7) ? 7 : 0;
                end
            endcase
            for (k = 0; k < PHASE_LEN; k++) send_sample(1'($urandom_range(1)), next_raw());
            i_valid <= 1'b0;

            if (ph == 3) begin
                // long receiver hold-off while the sender keeps offering
                drain();
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                recv_hold_left = 60;
                for (k = 0; k < 40; k++) send_sample(1'($urandom_range(1)), next_raw());
                i_valid <= 1'b0;
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS ir_adc_to_distance_interp_core");
        end else begin
            $display("FAIL ir_adc_to_distance_interp_core");
        end
        $finish;
    end

endmodule
